@@ rtl/sorted_priority_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Sorted priority queue: assertion macros
// Shared property macros for the queue's checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue: package
// Request codes, payload structs, controller states and control bundles.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam logic [1:0] REQ_ENQ = 2'd0;
	localparam logic [1:0] REQ_DEQ = 2'd1;
	localparam logic [1:0] REQ_REM = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] item_data;
		logic signed [31:0] item_priority;
	} spq_in_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] entry_count;
		logic [3:0] removed_count;
	} spq_out_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic signed [31:0] pri;
	} spq_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_INS_WALK,
		ST_INS_PLACE,
		ST_REM_SCAN,
		ST_FINISH
	} spq_state_t;

	typedef struct packed {
		logic take;
		logic ins_init;
		logic ins_shift;
		logic ins_place;
		logic rem_init;
		logic rem_step;
		logic deq;
		logic fail;
		logic emit;
	} spq_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       cnt_zero;
		logic       full;
		logic       greater;
		logic       at_head;
		logic       last;
		logic       out_free;
	} spq_sts_t;

endpackage

@@ rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue: top level
// Bounded queue of (data, priority) entries kept in ascending priority order.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_stall  | spq_in_t  (req_type, item_data, item_priority)
//   rsp     | out | rsp_valid/rsp_stall  | spq_out_t (ok, entry_count, removed_count)
//
// Enqueue: walks from the tail, shifting up each entry above the new priority,
// until the walk stops on a lower or equal entry or reaches the head; an empty
// queue skips the walk and places the new entry directly.
// Remove-priority: scans the held entries, one RAM read per held entry.
// Dequeue and failed requests skip the walk. The entry RAM port sets the walk rate.
// Reset empties the queue; the entry RAM needs no clearing.
// A stalled result holds the next request in its final cycle until transferred.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int CAPACITY = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  spq_pkg::spq_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output spq_pkg::spq_out_t rsp
);

	import spq_pkg::*;

	spq_cmd_t cmd;
	spq_sts_t sts;
	logic     idle;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.idle     (idle),
		.sts      (sts),
		.cmd      (cmd)
	);

	spq_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	assign req_stall = !idle;

endmodule

@@ rtl/spq_ram.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 10,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue: controller
// Sequences insertion walk, removal scan, dequeue and result transfer.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              idle,
	input  spq_pkg::spq_sts_t sts,
	output spq_pkg::spq_cmd_t cmd
);

	import spq_pkg::*;

	spq_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = ST_START;
				end
			end
			ST_START: begin
				case (sts.req_type)
					REQ_ENQ: begin
						if (sts.full) begin
							state_nxt = ST_FINISH;
						end else if (sts.cnt_zero) begin
							state_nxt = ST_INS_PLACE;
						end else begin
							state_nxt = ST_INS_WALK;
						end
					end
					REQ_REM: begin
						state_nxt = sts.cnt_zero ? ST_FINISH : ST_REM_SCAN;
					end
					default: begin
						state_nxt = ST_FINISH;
					end
				endcase
			end
			ST_INS_WALK: begin
				if (!sts.greater || sts.at_head) begin
					state_nxt = ST_INS_PLACE;
				end
			end
			ST_INS_PLACE: begin
				state_nxt = ST_FINISH;
			end
			ST_REM_SCAN: begin
				if (sts.last) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		idle = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle     = 1'b1;
				cmd.take = req_valid;
			end
			ST_START: begin
				case (sts.req_type)
					REQ_ENQ: begin
						cmd.fail     = sts.full;
						cmd.ins_init = !sts.full;
					end
					REQ_DEQ: begin
						cmd.fail = sts.cnt_zero;
						cmd.deq  = !sts.cnt_zero;
					end
					REQ_REM: begin
						cmd.rem_init = 1'b1;
					end
					default: begin
						cmd.fail = 1'b1;
					end
				endcase
			end
			ST_INS_WALK: begin
				cmd.ins_shift = sts.greater;
			end
			ST_INS_PLACE: begin
				cmd.ins_place = 1'b1;
			end
			ST_REM_SCAN: begin
				cmd.rem_step = 1'b1;
			end
			ST_FINISH: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/spq_dp.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue: datapath
// Entry RAM, count, walk indexes and the result register.
// ----------------------------------------------------------------------------
module spq_dp #(
	parameter int CAPACITY = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spq_pkg::spq_cmd_t cmd,
	output spq_pkg::spq_sts_t sts,
	input  spq_pkg::spq_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output spq_pkg::spq_out_t rsp
);

	import spq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	spq_in_t    req_q;
	spq_out_t   rsp_q;
	logic       rsp_valid_q;
	logic       ok_q;
	logic [CW-1:0] count_q, idx_q, w_q, removed_q;
	logic [CW-1:0] cnt_m1, idx_m1, idx_m2, idx_p1, w_p1;

	logic       we, re;
	logic [AW-1:0] waddr, raddr;
	spq_entry_t wdata, rdata;
	logic       match, greater, last;

	spq_ram #(
		.WIDTH ($bits(spq_entry_t)),
		.DEPTH (CAPACITY),
		.ADDR_W(AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign cnt_m1  = count_q - CW'(1);
	assign idx_m1  = idx_q - CW'(1);
	assign idx_m2  = idx_q - CW'(2);
	assign idx_p1  = idx_q + CW'(1);
	assign w_p1    = w_q + CW'(1);
	assign match   = $signed(rdata.pri) == $signed(req_q.item_priority);
	assign greater = $signed(rdata.pri) > $signed(req_q.item_priority);
	assign last    = idx_q == cnt_m1;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = idx_q[AW-1:0];
		raddr = cnt_m1[AW-1:0];
		wdata = rdata;
		if (cmd.ins_init) begin
			re    = count_q != '0;
			raddr = cnt_m1[AW-1:0];
		end
		if (cmd.ins_shift) begin
			we    = 1'b1;
			waddr = idx_q[AW-1:0];
			re    = idx_q > CW'(1);
			raddr = idx_m2[AW-1:0];
		end
		if (cmd.ins_place) begin
			we         = 1'b1;
			waddr      = idx_q[AW-1:0];
			wdata.data = req_q.item_data;
			wdata.pri  = req_q.item_priority;
		end
		if (cmd.rem_init) begin
			re    = count_q != '0;
			raddr = '0;
		end
		if (cmd.rem_step) begin
			we    = !match;
			waddr = w_q[AW-1:0];
			re    = idx_p1 < count_q;
			raddr = idx_p1[AW-1:0];
		end
	end

	always_comb begin
		sts.req_type = req_q.req_type;
		sts.cnt_zero = count_q == '0;
		sts.full     = count_q == CW'(CAPACITY);
		sts.greater  = greater;
		sts.at_head  = idx_q == CW'(1);
		sts.last     = last;
		sts.out_free = !rsp_valid_q || !rsp_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_place) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.deq) begin
				count_q <= cnt_m1;
			end else if (cmd.rem_step && last) begin
				count_q <= match ? w_q : w_p1;
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q <= req;
		end
		if (cmd.ins_init) begin
			idx_q     <= count_q;
			ok_q      <= 1'b1;
			removed_q <= '0;
		end
		if (cmd.ins_shift) begin
			idx_q <= idx_m1;
		end
		if (cmd.rem_init) begin
			idx_q     <= '0;
			w_q       <= '0;
			ok_q      <= 1'b1;
			removed_q <= '0;
		end
		if (cmd.rem_step) begin
			idx_q <= idx_p1;
			if (match) begin
				removed_q <= removed_q + CW'(1);
			end else begin
				w_q <= w_p1;
			end
		end
		if (cmd.deq) begin
			ok_q      <= 1'b1;
			removed_q <= CW'(1);
		end
		if (cmd.fail) begin
			ok_q      <= 1'b0;
			removed_q <= '0;
		end
		if (cmd.emit) begin
			rsp_q.ok            <= ok_q;
			rsp_q.entry_count   <= 4'(count_q);
			rsp_q.removed_count <= 4'(removed_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ rtl/spq_checker.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue: port checker
// Checks request/result behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_defines.svh"

module spq_port_checker #(
	parameter int CAPACITY = 10
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input spq_pkg::spq_in_t  req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input spq_pkg::spq_out_t rsp
);

	import spq_pkg::*;

	// one request in flight
	`SPQ_ASSERT_NEXT(a_one_in_flight, clk, arst_n,
		req_valid && !req_stall, req_stall, "request taken while busy")

	// failed request removes nothing
	`SPQ_ASSERT_NOW(a_fail_no_removal, clk, arst_n,
		rsp_valid && !rsp.ok, rsp.removed_count == 4'd0, "failed request reports a removal")

	// stalled result holds
	`SPQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n,
		rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

endmodule

bind sorted_priority_queue spq_port_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);
